// File: design/synchrophasor_config_frame_parser_macros.svh
// ----------------------------------------------------------------------------
// Synchrophasor configuration frame parser assertion macros
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef SYNCHROPHASOR_CONFIG_FRAME_PARSER_MACROS_SVH
`define SYNCHROPHASOR_CONFIG_FRAME_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCFP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scfp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SCFP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scfp assertion failed");

`endif

// File: design/scfp_pkg.sv
// ----------------------------------------------------------------------------
// Synchrophasor configuration frame parser package
// Field kind codes, frame layout constants and the result word type.
// ----------------------------------------------------------------------------
package scfp_pkg;

   localparam int POS_W   = 25;
   localparam int KIND_W  = 4;
   localparam int INDEX_W = 24;
   localparam int VALUE_W = 32;

   localparam logic [KIND_W-1:0] KIND_SIZE       = 4'd0;
   localparam logic [KIND_W-1:0] KIND_SOURCE_ID  = 4'd1;
   localparam logic [KIND_W-1:0] KIND_STATION    = 4'd2;
   localparam logic [KIND_W-1:0] KIND_FORMAT     = 4'd3;
   localparam logic [KIND_W-1:0] KIND_PHASOR_CNT = 4'd4;
   localparam logic [KIND_W-1:0] KIND_ANALOG_CNT = 4'd5;
   localparam logic [KIND_W-1:0] KIND_DIGITAL_CNT= 4'd6;
   localparam logic [KIND_W-1:0] KIND_PHASOR_NAME= 4'd7;
   localparam logic [KIND_W-1:0] KIND_ANALOG_NAME= 4'd8;
   localparam logic [KIND_W-1:0] KIND_DIGITAL_NAME = 4'd9;
   localparam logic [KIND_W-1:0] KIND_PHASOR_UNIT= 4'd10;
   localparam logic [KIND_W-1:0] KIND_ANALOG_UNIT= 4'd11;
   localparam logic [KIND_W-1:0] KIND_CHANGE_CNT = 4'd12;
   localparam logic [KIND_W-1:0] KIND_DATA_RATE  = 4'd13;

   localparam logic [5:0] BYTE_SIZE_END     = 6'd3;
   localparam logic [5:0] BYTE_SOURCE_END   = 6'd5;
   localparam logic [5:0] BYTE_STATION_FIRST= 6'd20;
   localparam logic [5:0] BYTE_STATION_LAST = 6'd35;
   localparam logic [5:0] BYTE_FORMAT_END   = 6'd39;
   localparam logic [5:0] BYTE_PHASOR_END   = 6'd41;
   localparam logic [5:0] BYTE_ANALOG_END   = 6'd43;
   localparam logic [5:0] BYTE_DIGITAL_END  = 6'd45;

   localparam logic [POS_W-1:0] HDR_END    = 25'd46;
   localparam logic [15:0]      FORMAT_MAX = 16'd15;

   typedef struct packed {
      logic               valid;
      logic [KIND_W-1:0]  kind;
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
      logic               done;
   } result_type;

endpackage

// File: design/scfp_parse_core.sv
// ----------------------------------------------------------------------------
// Synchrophasor configuration frame parser core
// Tracks the frame position and section bounds and decodes one byte per cycle while step is high.
// ----------------------------------------------------------------------------
module scfp_parse_core
   import scfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] frame_byte,
   input  logic       frame_start,
   output result_type result
);

   logic             active_ff, active_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [31:0]      word_ff, word_in;
   logic [15:0]      phasor_ff;
   logic [POS_W-1:0] an0_ff, dn0_ff, aub_ff, dub_ff;
   logic [POS_W-1:0] pu0_ff, au0_ff, du0_ff, cc_ff, dr_ff;

   logic             act;
   logic [POS_W-1:0] p;
   logic [15:0]      w16;
   logic             hdr;
   logic [POS_W-1:0] base;
   logic [POS_W-1:0] off;
   logic [POS_W-1:0] a16, p4, a4, d256, d4;
   logic [POS_W-1:0] dn0_next, aub_next, dub_next;
   result_type       res;

   assign act = frame_start | active_ff;
   assign p   = frame_start ? '0 : pos_ff;
   assign word_in = {word_ff[23:0], frame_byte};
   assign w16 = word_in[15:0];
   assign hdr = p < HDR_END;

   assign a16  = {5'd0, w16, 4'd0};
   assign a4   = {7'd0, w16, 2'd0};
   assign p4   = {7'd0, phasor_ff, 2'd0};
   assign d256 = {1'd0, w16, 8'd0};
   assign d4   = {7'd0, w16, 2'd0};
   assign dn0_next = an0_ff + a16;
   assign aub_next = dn0_next + p4;
   assign dub_next = aub_next + a4;

   assign base = (p < an0_ff) ? HDR_END :
                 (p < dn0_ff) ? an0_ff  :
                 (p < pu0_ff) ? dn0_ff  :
                 (p < au0_ff) ? pu0_ff  : au0_ff;
   assign off = p - base;

   always_comb begin
      res       = '0;
      active_in = active_ff;
      pos_in    = pos_ff;
      if (act) begin
         active_in = 1'b1;
         pos_in    = p + 1'b1;
         if (hdr) begin
            case (p[5:0])
               BYTE_SIZE_END: begin
                  res.valid = 1'b1;
                  res.kind  = KIND_SIZE;
                  res.value = {16'd0, w16};
               end
               BYTE_SOURCE_END: begin
                  res.valid = 1'b1;
                  res.kind  = KIND_SOURCE_ID;
                  res.value = {16'd0, w16};
               end
               BYTE_FORMAT_END: begin
                  res.valid = 1'b1;
                  res.kind  = KIND_FORMAT;
                  res.value = (w16 <= FORMAT_MAX) ? {16'd0, w16} : '0;
               end
               BYTE_PHASOR_END: begin
                  res.valid = 1'b1;
                  res.kind  = KIND_PHASOR_CNT;
                  res.value = {16'd0, w16};
               end
               BYTE_ANALOG_END: begin
                  res.valid = 1'b1;
                  res.kind  = KIND_ANALOG_CNT;
                  res.value = {16'd0, w16};
               end
               BYTE_DIGITAL_END: begin
                  res.valid = 1'b1;
                  res.kind  = KIND_DIGITAL_CNT;
                  res.value = {16'd0, w16};
               end
               default: begin
                  if (p[5:0] >= BYTE_STATION_FIRST && p[5:0] <= BYTE_STATION_LAST) begin
                     res.valid = 1'b1;
                     res.kind  = KIND_STATION;
                     res.index = {18'd0, p[5:0] - BYTE_STATION_FIRST};
                     res.value = {24'd0, frame_byte};
                  end
               end
            endcase
         end else if (p < an0_ff) begin
            res.valid = 1'b1;
            res.kind  = KIND_PHASOR_NAME;
            res.index = off[INDEX_W-1:0];
            res.value = {24'd0, frame_byte};
         end else if (p < dn0_ff) begin
            res.valid = 1'b1;
            res.kind  = KIND_ANALOG_NAME;
            res.index = off[INDEX_W-1:0];
            res.value = {24'd0, frame_byte};
         end else if (p < pu0_ff) begin
            res.valid = 1'b1;
            res.kind  = KIND_DIGITAL_NAME;
            res.index = off[INDEX_W-1:0];
            res.value = {24'd0, frame_byte};
         end else if (p < au0_ff) begin
            res.valid = &off[1:0];
            res.kind  = KIND_PHASOR_UNIT;
            res.index = {1'b0, off[POS_W-1:2]};
            res.value = word_in;
         end else if (p < du0_ff) begin
            res.valid = &off[1:0];
            res.kind  = KIND_ANALOG_UNIT;
            res.index = {1'b0, off[POS_W-1:2]};
            res.value = word_in;
         end else if (p == cc_ff) begin
            res.valid = 1'b1;
            res.kind  = KIND_CHANGE_CNT;
            res.value = {16'd0, w16};
         end else if (p == dr_ff) begin
            res.valid = 1'b1;
            res.kind  = KIND_DATA_RATE;
            res.value = {16'd0, w16};
            res.done  = 1'b1;
            active_in = 1'b0;
            pos_in    = '0;
         end
      end
   end

   assign result = step ? res : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= '0;
         word_ff   <= '0;
      end else if (step && act) begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
         word_ff   <= word_in;
      end
   end

   // Section bounds are built up as the counts arrive, so the body needs only compares.
   always_ff @(posedge clock) begin
      if (step && act && hdr) begin
         if (p[5:0] == BYTE_PHASOR_END) begin
            phasor_ff <= w16;
            an0_ff    <= HDR_END + a16;
         end
         if (p[5:0] == BYTE_ANALOG_END) begin
            dn0_ff <= dn0_next;
            aub_ff <= aub_next;
            dub_ff <= dub_next;
         end
         if (p[5:0] == BYTE_DIGITAL_END) begin
            pu0_ff <= dn0_ff + d256;
            au0_ff <= aub_ff + d256;
            du0_ff <= dub_ff + d256;
            cc_ff  <= dub_ff + d256 + d4 + 25'd3;
            dr_ff  <= dub_ff + d256 + d4 + 25'd5;
         end
      end
   end

endmodule

// File: design/synchrophasor_config_frame_parser.sv
// ----------------------------------------------------------------------------
// Synchrophasor configuration frame parser
// Splits a configuration frame, fed one byte per word, into its fields.
// ----------------------------------------------------------------------------
// The req channel carries one frame byte per word in req_tdata; req_tuser is
// high on the first byte of a frame and restarts parsing even in mid-frame.
// Bytes that arrive while no frame is active are consumed and dropped.
// The rsp channel emits one word per completed field or name byte: rsp_tuser
// holds the field kind, rsp_tdata the index within its section and the value,
// and rsp_tlast is high on the data rate word that closes the frame.
// A byte is registered on acceptance and decoded from the input register
// into the result register that drives rsp. One byte per cycle is sustained
// while rsp_tready is high; decode is position compares and one subtract.
// When rsp_tready is low the result register holds its word and the byte in
// the input register waits; req_tready falls only when both are occupied.
// Reset clears both registers and leaves the parser idle until a frame start.
module synchrophasor_config_frame_parser
   import scfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] frame_byte
   input  logic        req_tuser,  // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // [23:0] field_index, [55:24] field_value
   output logic [3:0]  rsp_tuser,  // [3:0] field_kind
   output logic        rsp_tlast   // frame_done
);

   logic        in_vld_ff;
   logic [7:0]  in_byte_ff;
   logic        in_start_ff;
   logic        rsp_vld_ff, rsp_vld_in;
   logic [55:0] rsp_data_ff;
   logic [3:0]  rsp_kind_ff;
   logic        rsp_last_ff;
   logic        advance;
   result_type  result;

   assign advance    = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   scfp_parse_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .frame_byte  (in_byte_ff),
      .frame_start (in_start_ff),
      .result      (result)
   );

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (advance) begin
         rsp_vld_in = result.valid;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
      if (advance) begin
         rsp_data_ff <= {result.value, result.index};
         rsp_kind_ff <= result.kind;
         rsp_last_ff <= result.done;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: design/scfp_checker.sv
// ----------------------------------------------------------------------------
// Synchrophasor configuration frame parser checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "synchrophasor_config_frame_parser_macros.svh"

module scfp_checker
   import scfp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [3:0]  rsp_tuser,
   input logic        rsp_tlast
);

   `SCFP_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
   `SCFP_ASSERT_SAME(a_last_is_rate, rsp_tvalid && rsp_tlast, rsp_tuser == KIND_DATA_RATE)
   `SCFP_ASSERT_SAME(a_kind_range, rsp_tvalid, rsp_tuser <= KIND_DATA_RATE)
   `SCFP_ASSERT_SAME(a_format_range, rsp_tvalid && rsp_tuser == KIND_FORMAT,
      rsp_tdata[55:24] <= 32'd15)
   `SCFP_ASSERT_NEXT(a_idle_no_rsp, !rsp_tvalid && !req_tvalid && !req_tready, !rsp_tvalid)

endmodule

bind synchrophasor_config_frame_parser scfp_checker u_scfp_checker (.*);
